@@ rtl/qsl_pkg.sv @@
// qsl_pkg: sequencer state type for the quicksort block
// no dependencies
package qsl_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_PIV_WAIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_PUSH2,
        ST_OUT_RD,
        ST_OUT_LD
    } qsl_state_t;

endpackage

@@ rtl/qsl_ram.sv @@
// qsl_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module qsl_ram #(
    parameter int WIDTH      = 32,
    parameter int DEPTH      = 64,
    parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/quicksort_lomuto_unit.sv @@
// quicksort_lomuto_unit: load, lomuto quicksort and ordered readout of a value set
// depends on qsl_pkg (state type) and qsl_ram (element store and range stack)
// loading stores each accepted item; sorting reads each item against the pivot, swaps
// by writing both items back and ends each range by placing its pivot; readout loads
// each result in order; sorted or all-equal sets need about N*N/2 compares
// reset (rst_n low, async): back to loading with an empty set, no result pending
module quicksort_lomuto_unit #(
    parameter int MAX_ITEMS  = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         end_of_run,
    output logic                         overflow
);

    import qsl_pkg::*;

    // index into the store, a count that can hold MAX_ITEMS, a compare width and a stack entry width
    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = IW + 1;
    localparam int SW = 2 * IW;

    // sequencer and bookkeeping
    qsl_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] sp_reg, sp_next;

    // partition working registers
    logic [IW-1:0]         lo_reg, lo_next;
    logic [IW-1:0]         hi_reg, hi_next;
    logic [IW-1:0]         place_reg, place_next;
    logic [IW-1:0]         j_reg, j_next;
    logic [IW-1:0]         k_reg, k_next;
    logic [DATA_WIDTH-1:0] pivot_reg, pivot_next;
    logic [DATA_WIDTH-1:0] cur_reg, cur_next;
    logic [DATA_WIDTH-1:0] tmp_reg, tmp_next;

    // output register, parts the sorter from the downstream stall
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic                  out_end_reg, out_end_next;
    logic                  out_ovf_reg, out_ovf_next;

    // memory ports
    logic                  st_wr_en;
    logic [IW-1:0]         st_wr_addr;
    logic [DATA_WIDTH-1:0] st_wr_data;
    logic                  st_rd_en;
    logic [IW-1:0]         st_rd_addr;
    logic [DATA_WIDTH-1:0] st_rd_data;

    logic          rs_wr_en;
    logic [IW-1:0] rs_wr_addr;
    logic [SW-1:0] rs_wr_data;
    logic          rs_rd_en;
    logic [IW-1:0] rs_rd_addr;
    logic [SW-1:0] rs_rd_data;

    logic          in_accept;
    logic          out_free;
    logic [CW-1:0] sp_dec;
    logic [CW-1:0] count_dec;
    logic [IW-1:0] pop_lo;
    logic [IW-1:0] pop_hi;
    logic          push_left;
    logic          push_right;
    logic          out_is_end;

    qsl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    // pending ranges never overlap and hold two or more items, so MAX_ITEMS entries suffice
    qsl_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ITEMS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (rs_wr_en),
        .wr_addr (rs_wr_addr),
        .wr_data (rs_wr_data),
        .rd_en   (rs_rd_en),
        .rd_addr (rs_rd_addr),
        .rd_data (rs_rd_data)
    );

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign sp_dec     = sp_reg - CW'(1);
    assign count_dec  = count_reg - CW'(1);
    assign pop_lo     = rs_rd_data[SW-1:IW];
    assign pop_hi     = rs_rd_data[IW-1:0];
    // split point is place_reg; recurse only on sides with two or more items
    assign push_left  = PW'(place_reg) > (PW'(lo_reg) + PW'(1));
    assign push_right = (PW'(place_reg) + PW'(1)) < PW'(hi_reg);
    assign out_is_end = (CW'(k_reg) == count_dec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        place_reg    <= place_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        pivot_reg    <= pivot_next;
        cur_reg      <= cur_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
        out_end_reg  <= out_end_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        place_next     = place_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pivot_next     = pivot_reg;
        cur_next       = cur_reg;
        tmp_next       = tmp_reg;
        out_data_next  = out_data_reg;
        out_end_next   = out_end_reg;
        out_ovf_next   = out_ovf_reg;
        // downstream takes the held item
        out_valid_next = out_valid_reg && out_stall;

        st_wr_en   = 1'b0;
        st_wr_addr = count_reg[IW-1:0];
        st_wr_data = value;
        st_rd_en   = 1'b0;
        st_rd_addr = j_reg;
        rs_wr_en   = 1'b0;
        rs_wr_addr = sp_reg[IW-1:0];
        rs_wr_data = {lo_reg, IW'(place_reg - IW'(1))};
        rs_rd_en   = 1'b0;
        rs_rd_addr = sp_dec[IW-1:0];

        case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    // store full: the item is dropped, but a last mark still starts the sort
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        st_wr_en   = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                k_next = '0;
                if (count_reg >= CW'(2))
                begin
                    rs_wr_en   = 1'b1;
                    rs_wr_addr = '0;
                    rs_wr_data = {IW'(0), count_dec[IW-1:0]};
                    sp_next    = CW'(1);
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    rs_rd_en   = 1'b1;
                    sp_next    = sp_dec;
                    state_next = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                lo_next    = pop_lo;
                hi_next    = pop_hi;
                place_next = pop_lo;
                j_next     = pop_lo;
                if ((pop_lo >= pop_hi) || (CW'(pop_hi) >= count_reg))
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    // pivot is the last item of the range
                    st_rd_en   = 1'b1;
                    st_rd_addr = pop_hi;
                    state_next = ST_PIV_WAIT;
                end
            end
            ST_PIV_WAIT:
            begin
                pivot_next = st_rd_data;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                st_rd_en = 1'b1;
                if (j_reg < hi_reg)
                begin
                    st_rd_addr = j_reg;
                    state_next = ST_SCAN_WAIT;
                end
                else
                begin
                    // scan done: pivot goes to place
                    st_rd_addr = place_reg;
                    state_next = ST_FIN_A;
                end
            end
            ST_SCAN_WAIT:
            begin
                cur_next = st_rd_data;
                if ($signed(st_rd_data) <= $signed(pivot_reg))
                begin
                    if (place_reg == j_reg)
                    begin
                        place_next = place_reg + IW'(1);
                        j_next     = j_reg + IW'(1);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        st_rd_en   = 1'b1;
                        st_rd_addr = place_reg;
                        state_next = ST_SWAP_A;
                    end
                end
                else
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SWAP_A:
            begin
                tmp_next   = st_rd_data;
                st_wr_en   = 1'b1;
                st_wr_addr = place_reg;
                st_wr_data = cur_reg;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = j_reg;
                st_wr_data = tmp_reg;
                place_next = place_reg + IW'(1);
                j_next     = j_reg + IW'(1);
                state_next = ST_SCAN;
            end
            ST_FIN_A:
            begin
                tmp_next   = st_rd_data;
                st_wr_en   = 1'b1;
                st_wr_addr = place_reg;
                st_wr_data = pivot_reg;
                state_next = ST_FIN_B;
            end
            ST_FIN_B:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = hi_reg;
                st_wr_data = tmp_reg;
                // left side first, right side on top so it is sorted next
                if (push_left && (sp_reg < CW'(MAX_ITEMS)))
                begin
                    rs_wr_en   = 1'b1;
                    rs_wr_data = {lo_reg, IW'(place_reg - IW'(1))};
                    sp_next    = sp_reg + CW'(1);
                end
                state_next = ST_PUSH2;
            end
            ST_PUSH2:
            begin
                if (push_right && (sp_reg < CW'(MAX_ITEMS)))
                begin
                    rs_wr_en   = 1'b1;
                    rs_wr_data = {IW'(place_reg + IW'(1)), hi_reg};
                    sp_next    = sp_reg + CW'(1);
                end
                state_next = ST_POP;
            end
            ST_OUT_RD:
            begin
                st_rd_en   = 1'b1;
                st_rd_addr = k_reg;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD:
            begin
                // ram read data holds until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = st_rd_data;
                    out_end_next   = out_is_end;
                    out_ovf_next   = drop_reg;
                    k_next         = k_reg + IW'(1);
                    if (out_is_end)
                    begin
                        count_next = '0;
                        sp_next    = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = $signed(out_data_reg);
    assign end_of_run   = out_end_reg;
    assign overflow     = out_ovf_reg;

endmodule
